/* src/abccq_pkg.sv */
// ----------------------------------------------------------------------------
// abccq_pkg
// Shared types, constants and helpers of the alpha-blend color-cube quantizer.
// ----------------------------------------------------------------------------
`default_nettype none

package abccq_pkg;

  localparam int unsigned NumChan   = 3;
  localparam int unsigned ChanW     = 8;
  localparam int unsigned ProdW     = 2 * ChanW;
  localparam int unsigned LevelW    = 3;
  localparam int unsigned CfgIdxW   = 2;

  localparam logic [ChanW-1:0] AlphaMin = 8'd16;
  localparam logic [ChanW-1:0] CubeBase = 8'd16;
  localparam logic [ChanW-1:0] FullOn   = 8'd255;

  // floor(x / 255) == (x * Recip255) >> Recip255Sh for every x below 2**16
  localparam logic [ProdW-1:0] Recip255   = 16'd32897;
  localparam int unsigned      Recip255Sh = 23;

  // register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_BG_RED   = 2'd0,
    CFG_BG_GREEN = 2'd1,
    CFG_BG_BLUE  = 2'd2
  } abccq_cfg_e;

  // channel order inside the packed channel vectors
  localparam int unsigned ChRed   = 2;
  localparam int unsigned ChGreen = 1;
  localparam int unsigned ChBlue  = 0;

  typedef logic [NumChan-1:0][ChanW-1:0]  chan_vec_t;
  typedef logic [NumChan-1:0][LevelW-1:0] level_vec_t;

  // control that travels with each pipeline stage
  typedef struct packed {
    logic valid;
    logic transp;
    logic last;
  } abccq_sb_t;

  // nearest cube level among 0,95,135,175,215,255; halfway goes to the lower one
  function automatic logic [LevelW-1:0] snap_level(input logic [ChanW-1:0] v);
    logic [LevelW-1:0] lvl;
    if (v <= 8'd47) begin
      lvl = 3'd0;
    end else if (v <= 8'd115) begin
      lvl = 3'd1;
    end else if (v <= 8'd155) begin
      lvl = 3'd2;
    end else if (v <= 8'd195) begin
      lvl = 3'd3;
    end else if (v <= 8'd235) begin
      lvl = 3'd4;
    end else begin
      lvl = 3'd5;
    end
    return lvl;
  endfunction

endpackage

`default_nettype wire

/* src/abccq_blend.sv */
// ----------------------------------------------------------------------------
// abccq_blend
// Two stages: per-channel products, then sum and exact divide by 255.
// ----------------------------------------------------------------------------
`default_nettype none

module abccq_blend (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 adv_i,
  input  wire abccq_pkg::abccq_sb_t sb_i,
  input  wire abccq_pkg::chan_vec_t color_i,
  input  wire logic [7:0]           alpha_i,
  input  wire abccq_pkg::chan_vec_t bg_i,
  output abccq_pkg::abccq_sb_t      sb_o,
  output abccq_pkg::chan_vec_t      blend_o
);
  import abccq_pkg::*;

  logic [NumChan-1:0][ProdW-1:0] prod_fg_q, prod_fg_d;
  logic [NumChan-1:0][ProdW-1:0] prod_bg_q, prod_bg_d;
  abccq_sb_t                     sb1_q, sb2_q;
  chan_vec_t                     quot_q, quot_d;
  logic [ChanW-1:0]              inv_alpha;
  logic [NumChan-1:0][ProdW-1:0] sum;
  logic [NumChan-1:0][2*ProdW-1:0] scaled;

  assign inv_alpha = FullOn - alpha_i;

  always_comb begin
    for (int i = 0; i < NumChan; i++) begin
      prod_fg_d[i] = ProdW'(color_i[i]) * ProdW'(alpha_i);
      prod_bg_d[i] = ProdW'(bg_i[i]) * ProdW'(inv_alpha);
    end
  end

  // both products sum to at most 255*255, so the sum fits 16 bits
  always_comb begin
    for (int i = 0; i < NumChan; i++) begin
      sum[i]    = prod_fg_q[i] + prod_bg_q[i];
      scaled[i] = (2*ProdW)'(sum[i]) * (2*ProdW)'(Recip255);
      quot_d[i] = scaled[i][Recip255Sh +: ChanW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sb1_q <= '0;
      sb2_q <= '0;
    end else if (adv_i) begin
      sb1_q <= sb_i;
      sb2_q <= sb1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      prod_fg_q <= prod_fg_d;
      prod_bg_q <= prod_bg_d;
      quot_q    <= quot_d;
    end
  end

  assign sb_o    = sb2_q;
  assign blend_o = quot_q;

endmodule

`default_nettype wire

/* src/abccq_snap.sv */
// ----------------------------------------------------------------------------
// abccq_snap
// Two stages: snap each channel to a cube level, then form the palette index.
// ----------------------------------------------------------------------------
`default_nettype none

module abccq_snap (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 adv_i,
  input  wire abccq_pkg::abccq_sb_t sb_i,
  input  wire abccq_pkg::chan_vec_t blend_i,
  output abccq_pkg::abccq_sb_t      sb_o,
  output logic [7:0]                index_o
);
  import abccq_pkg::*;

  abccq_sb_t        sb3_q, sb4_q;
  level_vec_t       lvl_q, lvl_d;
  logic [ChanW-1:0] index_q, index_d;

  always_comb begin
    for (int i = 0; i < NumChan; i++) begin
      lvl_d[i] = snap_level(blend_i[i]);
    end
  end

  always_comb begin
    if (sb3_q.transp) begin
      index_d = '0;
    end else begin
      index_d = CubeBase
              + ChanW'(lvl_q[ChRed])   * 8'd36
              + ChanW'(lvl_q[ChGreen]) * 8'd6
              + ChanW'(lvl_q[ChBlue]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sb3_q <= '0;
      sb4_q <= '0;
    end else if (adv_i) begin
      sb3_q <= sb_i;
      sb4_q <= sb3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      lvl_q   <= lvl_d;
      index_q <= index_d;
    end
  end

  assign sb_o    = sb4_q;
  assign index_o = index_q;

endmodule

`default_nettype wire

/* src/alpha_blend_color_cube_quantizer_top.sv */
// ----------------------------------------------------------------------------
// alpha_blend_color_cube_quantizer_top
// RGBA pixel to 6x6x6 color-cube palette index, blended over a background.
// ----------------------------------------------------------------------------
// Pipeline: the result passes through four register stages (products, divide
// by 255, level snap, index/output register); the first stage loads at the
// accepting edge itself.
// Throughput: one item per cycle; the whole pipe holds while the output
// register keeps an item that is not taken.
// Reset: pipeline valid bits and background color registers clear to zero.
`default_nettype none

module alpha_blend_color_cube_quantizer_top (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_idx_i,
  input  wire logic [7:0] cfg_data_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] red_in_i,
  input  wire logic [7:0] green_in_i,
  input  wire logic [7:0] blue_in_i,
  input  wire logic [7:0] alpha_in_i,
  input  wire logic       last_pixel_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      color_index_o,
  output logic            transparent_o,
  output logic            last_out_o
);
  import abccq_pkg::*;

  chan_vec_t bg_q;
  chan_vec_t color_in;
  chan_vec_t blend;
  abccq_sb_t sb_in, sb_mid, sb_out;
  logic      adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (abccq_cfg_e'(cfg_idx_i))
        CFG_BG_RED:   bg_q[ChRed]   <= cfg_data_i;
        CFG_BG_GREEN: bg_q[ChGreen] <= cfg_data_i;
        CFG_BG_BLUE:  bg_q[ChBlue]  <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  // advance every stage unless the output register holds an item not taken
  assign adv        = !sb_out.valid || out_ready_i;
  assign in_ready_o = adv;

  always_comb begin
    color_in[ChRed]   = red_in_i;
    color_in[ChGreen] = green_in_i;
    color_in[ChBlue]  = blue_in_i;
    sb_in.valid       = in_valid_i;
    sb_in.transp      = alpha_in_i < AlphaMin;
    sb_in.last        = last_pixel_i;
  end

  abccq_blend u_blend (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .sb_i    (sb_in),
    .color_i (color_in),
    .alpha_i (alpha_in_i),
    .bg_i    (bg_q),
    .sb_o    (sb_mid),
    .blend_o (blend)
  );

  abccq_snap u_snap (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .sb_i    (sb_mid),
    .blend_i (blend),
    .sb_o    (sb_out),
    .index_o (color_index_o)
  );

  assign out_valid_o   = sb_out.valid;
  assign transparent_o = sb_out.transp;
  assign last_out_o    = sb_out.last;

  a_transp_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && transparent_o |-> color_index_o == 8'd0)
    else $error("transparent item with nonzero index");

  a_index_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !transparent_o |-> color_index_o >= 8'd16 && color_index_o <= 8'd231)
    else $error("cube index out of range");

  a_hold_on_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(color_index_o) && !$past(in_ready_o))
    else $error("pipe moved while output stalled");

endmodule

`default_nettype wire
